[sv/oppr_pkg.sv]
// Shared types, codes and microcode program for the operating-point resolve block.
package oppr_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam logic [31:0] ENTRY_INVALID = 32'hFFFF_FFFF;

    // command codes
    localparam logic [2:0] CMD_LOAD    = 3'd0;
    localparam logic [2:0] CMD_REQUEST = 3'd1;
    localparam logic [2:0] CMD_TICK    = 3'd2;
    localparam logic [2:0] CMD_SET_CUR = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;

    // result status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_SAME     = 2'd1;
    localparam logic [1:0] ST_NO_MATCH = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    typedef logic [3:0] upc_t;

    // microcode addresses
    localparam upc_t A_IDLE = 4'd0;
    localparam upc_t A_LOAD = 4'd1;
    localparam upc_t A_RD0  = 4'd2;
    localparam upc_t A_RD1  = 4'd3;
    localparam upc_t A_TK0  = 4'd4;
    localparam upc_t A_TK1  = 4'd5;
    localparam upc_t A_SC0  = 4'd6;
    localparam upc_t A_SC1  = 4'd7;
    localparam upc_t A_SC2  = 4'd8;
    localparam upc_t A_MT0  = 4'd9;
    localparam upc_t A_MT1  = 4'd10;
    localparam upc_t A_MT2  = 4'd11;
    localparam upc_t A_CMT  = 4'd12;
    localparam upc_t A_UNK  = 4'd13;
    localparam upc_t A_DONE = 4'd14;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_ACCEPT,
        UOP_LOAD,
        UOP_RD_ISSUE,
        UOP_RD_CAPT,
        UOP_RES_ISSUE,
        UOP_RES_ADD,
        UOP_SCAN_INIT,
        UOP_SCAN_RD,
        UOP_SCAN_EVAL,
        UOP_MATCH_INIT,
        UOP_MATCH_EVAL,
        UOP_COMMIT,
        UOP_UNKNOWN,
        UOP_RESULT
    } uop_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_IN_ACC,
        C_SCAN_END,
        C_SCAN_GO,
        C_NOT_FOUND,
        C_MISS,
        C_NO_CUR,
        C_OUT_FREE
    } cond_t;

    // one control word: datapath operation, jump condition and target
    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        upc_t  tgt;
        logic  hold;      // stay on this step while the condition is false
        logic  dispatch;  // on a taken jump, go to the command's entry step
    } ctrl_t;

    // datapath conditions seen by the sequencer
    typedef struct packed {
        logic in_acc;
        logic scan_end;
        logic scan_go;
        logic not_found;
        logic miss;
        logic no_cur;
        logic out_free;
    } flags_t;

    function automatic ctrl_t cw(uop_t u, cond_t c, upc_t t, logic h, logic d);
        ctrl_t w;
        w.uop      = u;
        w.cond     = c;
        w.tgt      = t;
        w.hold     = h;
        w.dispatch = d;
        return w;
    endfunction

    function automatic ctrl_t ucode_rom(upc_t a);
        ctrl_t w;
        unique case (a)
            A_IDLE:  w = cw(UOP_ACCEPT,     C_IN_ACC,    A_IDLE, 1'b1, 1'b1);
            A_LOAD:  w = cw(UOP_LOAD,       C_ALWAYS,    A_DONE, 1'b0, 1'b0);
            A_RD0:   w = cw(UOP_RD_ISSUE,   C_NEVER,     A_IDLE, 1'b0, 1'b0);
            A_RD1:   w = cw(UOP_RD_CAPT,    C_ALWAYS,    A_DONE, 1'b0, 1'b0);
            A_TK0:   w = cw(UOP_RES_ISSUE,  C_NO_CUR,    A_DONE, 1'b0, 1'b0);
            A_TK1:   w = cw(UOP_RES_ADD,    C_ALWAYS,    A_DONE, 1'b0, 1'b0);
            A_SC0:   w = cw(UOP_SCAN_INIT,  C_NEVER,     A_IDLE, 1'b0, 1'b0);
            A_SC1:   w = cw(UOP_SCAN_RD,    C_SCAN_END,  A_MT0,  1'b0, 1'b0);
            A_SC2:   w = cw(UOP_SCAN_EVAL,  C_SCAN_GO,   A_SC1,  1'b0, 1'b0);
            A_MT0:   w = cw(UOP_MATCH_INIT, C_NOT_FOUND, A_CMT,  1'b0, 1'b0);
            A_MT1:   w = cw(UOP_SCAN_RD,    C_NEVER,     A_IDLE, 1'b0, 1'b0);
            A_MT2:   w = cw(UOP_MATCH_EVAL, C_MISS,      A_MT1,  1'b0, 1'b0);
            A_CMT:   w = cw(UOP_COMMIT,     C_ALWAYS,    A_DONE, 1'b0, 1'b0);
            A_UNK:   w = cw(UOP_UNKNOWN,    C_NEVER,     A_IDLE, 1'b0, 1'b0);
            A_DONE:  w = cw(UOP_RESULT,     C_OUT_FREE,  A_IDLE, 1'b1, 1'b0);
            default: w = cw(UOP_NOP,        C_ALWAYS,    A_IDLE, 1'b0, 1'b0);
        endcase
        return w;
    endfunction

    function automatic upc_t dispatch_target(logic [2:0] cmd);
        upc_t t;
        unique case (cmd)
            CMD_LOAD:    t = A_LOAD;
            CMD_REQUEST: t = A_SC0;
            CMD_TICK:    t = A_TK0;
            CMD_SET_CUR: t = A_SC0;
            CMD_READ:    t = A_RD0;
            default:     t = A_UNK;
        endcase
        return t;
    endfunction

endpackage

[sv/oppr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module oppr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/oppr_useq.sv]
// Microcode sequencer: step counter, control store and jump logic.
module oppr_useq
    import oppr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  flags_t     flags,
    input  logic [2:0] in_cmd,
    output ctrl_t      ctrl
);

    upc_t upc_reg;
    upc_t upc_next;
    logic cond_true;

    assign ctrl = ucode_rom(upc_reg);

    always_comb begin
        unique case (ctrl.cond)
            C_NEVER:     cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_IN_ACC:    cond_true = flags.in_acc;
            C_SCAN_END:  cond_true = flags.scan_end;
            C_SCAN_GO:   cond_true = flags.scan_go;
            C_NOT_FOUND: cond_true = flags.not_found;
            C_MISS:      cond_true = flags.miss;
            C_NO_CUR:    cond_true = flags.no_cur;
            C_OUT_FREE:  cond_true = flags.out_free;
            default:     cond_true = 1'b1;
        endcase

        priority if (cond_true && ctrl.dispatch) begin
            upc_next = dispatch_target(in_cmd);
        end else if (cond_true) begin
            upc_next = ctrl.tgt;
        end else if (ctrl.hold) begin
            upc_next = upc_reg;
        end else begin
            upc_next = upc_reg + upc_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= A_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

[sv/opp_resolve_and_residency_top.sv]
// Top level: operating-point table, resolve scan, residency counters and channels.
//
// Holds a table of TABLE_DEPTH frequency slots (all ones marks an invalid slot),
// the current frequency and slot, a transition counter and one saturating 64-bit
// residency counter per slot. The table size in use is set by a single config
// write (cfg_table_entries; values above TABLE_DEPTH act as TABLE_DEPTH); the
// user must change it only while the block is idle; the block itself does not
// enforce this. Every input transaction yields exactly one result transaction.
// Items are handled one at a time by a microcoded sequencer; the frequency
// table and residency counters sit in RAMs with a registered read. A request
// or set-current runs a resolve pass over the active slots and then, if a value
// was found, a match pass that finds the lowest slot holding the resolved
// value. A new transaction is accepted while the previous result still waits
// on m_ready; the block stalls only when a second result is ready before the
// first is taken. No transaction or config write is taken while reset is
// asserted. No clearing pass follows reset: residency counters read as zero
// until first written.
module opp_resolve_and_residency_top
    import oppr_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_table_entries,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [3:0]  s_slot_index,
    input  logic [31:0] s_freq_value,
    input  logic        s_relation,
    input  logic [15:0] s_elapsed,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_resolved_freq,
    output logic [31:0] m_current_freq,
    output logic [31:0] m_transition_total,
    output logic [31:0] m_slot_freq,
    output logic [63:0] m_slot_residency
);

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int VLD_N = 1 << AW;

    ctrl_t  ctrl;
    flags_t flags;

    // config and architectural state
    logic [4:0]       tbl_entries_reg;
    logic [31:0]      cur_freq_reg,  cur_freq_next;
    logic [CNT_W-1:0] cur_slot_reg,  cur_slot_next;
    logic [31:0]      trans_reg,     trans_next;
    logic [VLD_N-1:0] res_vld_reg,   res_vld_next;
    logic             res_rd_vld_reg;

    // latched transaction
    logic [2:0]  cmd_reg;
    logic [3:0]  slot_reg;
    logic [31:0] freq_reg;
    logic        mode_h_reg;
    logic [15:0] elapsed_reg;

    // scan working registers
    logic [CNT_W-1:0] idx_reg,   idx_next;
    logic [31:0]      best_reg,  best_next;
    logic             found_reg, found_next;
    logic [CNT_W-1:0] mslot_reg, mslot_next;

    // result being built
    logic [1:0]  status_reg,   status_next;
    logic [31:0] resolved_reg, resolved_next;
    logic [31:0] sfreq_reg,    sfreq_next;
    logic [63:0] sres_reg,     sres_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_status_reg;
    logic [31:0] m_resolved_reg;
    logic [31:0] m_cur_reg;
    logic [31:0] m_trans_reg;
    logic [31:0] m_sfreq_reg;
    logic [63:0] m_sres_reg;

    // RAM ports
    logic          f_we;
    logic [AW-1:0] f_raddr;
    logic [31:0]   f_rdata;
    logic          r_we;
    logic [AW-1:0] r_raddr;
    logic [63:0]   r_rdata;
    logic [63:0]   r_wdata;

    logic             s_acc;
    logic             slot_ok;
    logic [CNT_W-1:0] n_active;
    logic             entry_valid;
    logic             stop_now;
    logic [63:0]      res_eff;
    logic [64:0]      res_sum;
    logic             out_free;
    logic             load_out;

    // Hold both ready lines low while reset is asserted.
    assign cfg_ready = aresetn;
    assign s_ready   = (ctrl.uop == UOP_ACCEPT) && aresetn;
    assign s_acc     = s_valid && s_ready;

    // Clamp the configured size to the table depth.
    assign n_active = (32'(tbl_entries_reg) > 32'(TABLE_DEPTH)) ?
                      CNT_W'(TABLE_DEPTH) : CNT_W'(tbl_entries_reg);
    assign slot_ok  = (32'(slot_reg) < 32'(TABLE_DEPTH));

    // Resolve pass: mode L stops at the first valid entry at or above the target,
    // mode H stops at the first valid entry above it.
    assign entry_valid = (f_rdata != ENTRY_INVALID);
    assign stop_now    = entry_valid && (mode_h_reg ? (f_rdata > freq_reg)
                                                    : (f_rdata >= freq_reg));

    // Residency: unwritten counters read as zero; the add saturates.
    assign res_eff = res_rd_vld_reg ? r_rdata : 64'd0;
    assign res_sum = {1'b0, res_eff} + {49'd0, elapsed_reg};
    assign r_wdata = res_sum[64] ? {64{1'b1}} : res_sum[63:0];

    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (ctrl.uop == UOP_RESULT) && out_free;

    assign flags.in_acc    = s_acc;
    assign flags.scan_end  = (idx_reg >= n_active);
    assign flags.scan_go   = !stop_now;
    assign flags.not_found = !found_reg;
    assign flags.miss      = (f_rdata != best_reg);
    assign flags.no_cur    = (cur_slot_reg == CNT_W'(TABLE_DEPTH));
    assign flags.out_free  = out_free;

    // RAM addressing: slot reads use the transaction's slot, scans the index,
    // residency updates the current slot.
    assign f_we    = (ctrl.uop == UOP_LOAD) && slot_ok;
    assign f_raddr = (ctrl.uop == UOP_RD_ISSUE) ? AW'(slot_reg) : idx_reg[AW-1:0];
    assign r_we    = (ctrl.uop == UOP_RES_ADD);
    assign r_raddr = (ctrl.uop == UOP_RD_ISSUE) ? AW'(slot_reg) : cur_slot_reg[AW-1:0];

    oppr_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .in_cmd  (s_cmd),
        .ctrl    (ctrl)
    );

    oppr_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_freq_ram (
        .aclk  (aclk),
        .we    (f_we),
        .waddr (AW'(slot_reg)),
        .wdata (freq_reg),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    oppr_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_DEPTH)
    ) u_res_ram (
        .aclk  (aclk),
        .we    (r_we),
        .waddr (cur_slot_reg[AW-1:0]),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    // Datapath next-state, one micro-operation per cycle.
    always_comb begin
        cur_freq_next = cur_freq_reg;
        cur_slot_next = cur_slot_reg;
        trans_next    = trans_reg;
        res_vld_next  = res_vld_reg;
        idx_next      = idx_reg;
        best_next     = best_reg;
        found_next    = found_reg;
        mslot_next    = mslot_reg;
        status_next   = status_reg;
        resolved_next = resolved_reg;
        sfreq_next    = sfreq_reg;
        sres_next     = sres_reg;

        unique case (ctrl.uop)
            UOP_ACCEPT: begin
                status_next   = ST_DONE;
                resolved_next = 32'd0;
                sfreq_next    = 32'd0;
                sres_next     = 64'd0;
            end
            UOP_LOAD: begin
                if (!slot_ok) begin
                    status_next = ST_RANGE;
                end
            end
            UOP_RD_CAPT: begin
                if (slot_ok) begin
                    sfreq_next = f_rdata;
                    sres_next  = res_eff;
                end else begin
                    status_next = ST_RANGE;
                end
            end
            UOP_RES_ADD: begin
                res_vld_next[cur_slot_reg[AW-1:0]] = 1'b1;
            end
            UOP_SCAN_INIT: begin
                idx_next   = '0;
                best_next  = 32'd0;
                found_next = 1'b0;
            end
            UOP_SCAN_EVAL: begin
                // mode H keeps the last entry at or below the target
                if (entry_valid && !(mode_h_reg && stop_now)) begin
                    best_next  = f_rdata;
                    found_next = 1'b1;
                end
                idx_next = idx_reg + CNT_W'(1);
            end
            UOP_MATCH_INIT: begin
                idx_next = '0;
            end
            UOP_MATCH_EVAL: begin
                // lowest slot holding the resolved value
                if (f_rdata == best_reg) begin
                    mslot_next = idx_reg;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            UOP_COMMIT: begin
                if (!found_reg) begin
                    status_next = ST_NO_MATCH;
                end else begin
                    resolved_next = best_reg;
                    if (cmd_reg == CMD_REQUEST) begin
                        if (best_reg == cur_freq_reg) begin
                            status_next = ST_SAME;
                        end else begin
                            trans_next    = trans_reg + 32'd1;
                            cur_freq_next = best_reg;
                            cur_slot_next = mslot_reg;
                        end
                    end else begin
                        // set current moves the slot even at the same frequency
                        status_next   = (best_reg == cur_freq_reg) ? ST_SAME : ST_DONE;
                        cur_freq_next = best_reg;
                        cur_slot_next = mslot_reg;
                    end
                end
            end
            UOP_UNKNOWN: begin
                status_next = ST_SAME;
            end
            default: begin
            end
        endcase

        priority if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control and architectural state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tbl_entries_reg <= 5'd0;
            cur_freq_reg    <= 32'd0;
            cur_slot_reg    <= CNT_W'(TABLE_DEPTH);
            trans_reg       <= 32'd0;
            res_vld_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                tbl_entries_reg <= cfg_table_entries;
            end
            cur_freq_reg <= cur_freq_next;
            cur_slot_reg <= cur_slot_next;
            trans_reg    <= trans_next;
            res_vld_reg  <= res_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cmd_reg     <= s_cmd;
            slot_reg    <= s_slot_index;
            freq_reg    <= s_freq_value;
            mode_h_reg  <= (s_cmd == CMD_REQUEST) && s_relation;
            elapsed_reg <= s_elapsed;
        end
        res_rd_vld_reg <= res_vld_reg[r_raddr];
        idx_reg        <= idx_next;
        best_reg       <= best_next;
        found_reg      <= found_next;
        mslot_reg      <= mslot_next;
        status_reg     <= status_next;
        resolved_reg   <= resolved_next;
        sfreq_reg      <= sfreq_next;
        sres_reg       <= sres_next;
        if (load_out) begin
            m_status_reg   <= status_reg;
            m_resolved_reg <= resolved_reg;
            m_cur_reg      <= cur_freq_reg;
            m_trans_reg    <= trans_reg;
            m_sfreq_reg    <= sfreq_reg;
            m_sres_reg     <= sres_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_resolved_freq    = m_resolved_reg;
    assign m_current_freq     = m_cur_reg;
    assign m_transition_total = m_trans_reg;
    assign m_slot_freq        = m_sfreq_reg;
    assign m_slot_residency   = m_sres_reg;

endmodule

[sv/oppr_checker.sv]
// Port-level checks for the operating-point resolve block, bound to the top level.
module oppr_checker
    import oppr_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [31:0] m_resolved_freq,
    input logic [31:0] m_transition_total,
    input logic [31:0] m_slot_freq,
    input logic [63:0] m_slot_residency
);

    logic        m_acc;
    logic        have_prev_reg;
    logic [31:0] prev_trans_reg;

    assign m_acc = m_valid && m_ready;

    // Track the transition count of the last delivered result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg  <= 1'b0;
            prev_trans_reg <= 32'd0;
        end else if (m_acc) begin
            have_prev_reg  <= 1'b1;
            prev_trans_reg <= m_transition_total;
        end
    end

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_transition_total))
        else $error("result dropped or changed while stalled");

    a_no_match_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_NO_MATCH) |-> (m_resolved_freq == 32'd0))
        else $error("no-match result carries a resolved frequency");

    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_RANGE) |->
            (m_slot_freq == 32'd0) && (m_slot_residency == 64'd0)
            && (m_resolved_freq == 32'd0))
        else $error("out-of-range result carries slot data");

    a_trans_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_acc && have_prev_reg |->
            (m_transition_total == prev_trans_reg)
            || (m_transition_total == prev_trans_reg + 32'd1))
        else $error("transition count moved by more than one per result");

endmodule

bind opp_resolve_and_residency_top oppr_checker u_oppr_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_status           (m_status),
    .m_resolved_freq    (m_resolved_freq),
    .m_transition_total (m_transition_total),
    .m_slot_freq        (m_slot_freq),
    .m_slot_residency   (m_slot_residency)
);
